### design/vod_pkg.sv
// Package with shared constants, types and the memory entry layout of the oscillation detector.
package vod_pkg;

   localparam int WINDOW_DEPTH = 32;
   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = 16 + PTR_W + 1;
   localparam int ENTRY_W = 34;
   localparam int ADDR_W = 3;
   localparam int QUO_W = 28;

   localparam logic [ADDR_W-1:0] REG_FWD_LIMIT = 3'd0;
   localparam logic [ADDR_W-1:0] REG_REV_LIMIT = 3'd1;
   localparam logic [ADDR_W-1:0] REG_TURN_LIMIT = 3'd2;
   localparam logic [ADDR_W-1:0] REG_SPEED_THR = 3'd3;
   localparam logic [ADDR_W-1:0] REG_TURN_THR = 3'd4;
   localparam logic [ADDR_W-1:0] REG_WIN_LEN = 3'd5;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // One window entry: normalized speed, normalized turn rate and raw turn sign.
   typedef struct packed {
      logic signed [15:0] speed;
      logic signed [15:0] turn;
      logic signed [1:0] sign;
   } entry_type;

   // Control between the top level and the divider.
   typedef struct packed {
      logic start;
      logic negative;
      logic bypass;
   } div_ctrl_type;

endpackage

### design/vod_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
module vod_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### design/vod_divider.sv
// Restoring divider that normalizes one Q8.8 magnitude to a saturated signed Q4.12 value.
module vod_divider import vod_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  div_ctrl_type       ctrl,
   input  logic [15:0]        magnitude,
   input  logic [14:0]        divisor,
   output logic               done,
   output logic signed [15:0] result
);

   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [4:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic neg_ff, neg_in;
   logic [14:0] div_ff, div_in;
   logic [15:0] trial;
   logic [QUO_W-1:0] mag_q;
   logic signed [16:0] sat_val;

   // One quotient bit per cycle over the 28-bit dividend magnitude*4096.
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      neg_in = neg_ff;
      div_in = div_ff;
      done_in = 1'b0;
      trial = {rem_ff[14:0], quo_ff[QUO_W-1]};
      if (ctrl.start) begin
         quo_in = {magnitude, 12'd0};
         rem_in = '0;
         step_in = 5'(QUO_W - 1);
         busy_in = !ctrl.bypass;
         done_in = ctrl.bypass;
         neg_in = ctrl.negative;
         div_in = divisor;
         if (ctrl.bypass) begin
            quo_in = {7'd0, magnitude, 5'd0} >> 1;
         end
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         step_in = step_ff - 5'd1;
         if (step_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
      neg_ff <= neg_in;
      div_ff <= div_in;
   end

   // Sign and saturation of the finished quotient; bypass holds magnitude*16.
   assign mag_q = quo_ff;
   always_comb begin
      if (mag_q > 28'd32768) begin
         sat_val = neg_ff ? -17'sd32768 : 17'sd32767;
      end else if (mag_q == 28'd32768) begin
         sat_val = neg_ff ? -17'sd32768 : 17'sd32767;
      end else begin
         sat_val = neg_ff ? -$signed({2'b00, mag_q[14:0]}) : $signed({2'b00, mag_q[14:0]});
      end
   end

   assign done = done_ff;
   assign result = sat_val[15:0];

   // A bypassed item skips the quotient loop; done is registered from the start request.
   a_byp_quick: assert property (@(posedge clock) disable iff (reset)
      (ctrl.start && ctrl.bypass) |=> done)
      else $error("bypass result late");

endmodule

### design/velocity_oscillation_detector.sv
// Top level of the velocity oscillation detector: register port, window memory and sequencer.
// Each velocity sample is normalized in speed and then in turn rate: the two normalizations
// run one after the other through one shared radix-2 divider, and each computes 28 quotient
// bits on a nonzero limit and bypasses the quotient loop on a zero limit; then come the
// window memory read steps ST_RD0 and ST_RD1, the update step ST_UPD and the step ST_OUT
// that loads the result register. A clear operation resets the window state and goes
// straight to the result step. The window memory holds WINDOW_DEPTH entries and needs no
// clearing pass; the fill count bounds which entries are read. One item is in flight at
// a time, and the next one is taken as soon as the result register is free or being drained.
module velocity_oscillation_detector import vod_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic signed [15:0] req_linear_speed,
   input  logic signed [15:0] req_turn_rate,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_oscillating,
   output logic               rsp_detecting,
   output logic [5:0]         rsp_sample_count,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SPEED = 7'b0000010,
      ST_TURN  = 7'b0000100,
      ST_RD0   = 7'b0001000,
      ST_RD1   = 7'b0010000,
      ST_UPD   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [14:0] fwd_ff, rev_ff, trl_ff, sthr_ff, tthr_ff;
   logic [5:0] wlen_ff;
   logic signed [SUM_W-1:0] ssum_ff, ssum_in, tsum_ff, tsum_in;
   logic [PTR_W-1:0] scc_ff, scc_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic signed [1:0] nsign_ff, nsign_in;
   logic flag_ff, flag_in;
   logic signed [15:0] lin_ff, trn_ff, nspd_ff, nspd_in;
   logic signed [15:0] ntrn_ff, ntrn_in;
   entry_type old_ff, old_in;
   logic rv_ff, rv_in;
   logic ro_ff, ro_in, rd_ff, rd_in;
   logic [5:0] rc_ff, rc_in;
   logic cfg_wr, clear_win;
   logic [ADDR_W-1:0] reg_idx;
   div_ctrl_type dctl;
   logic [15:0] dmag;
   logic [14:0] ddiv;
   logic ddone;
   logic signed [15:0] dres;
   logic ram_we;
   logic [PTR_W-1:0] ram_ra;
   entry_type ram_wd, ram_rd;
   logic [5:0] len;
   logic [PTR_W-1:0] wp_eff, nxt_ptr;
   logic [14:0] lin_abs, trn_abs;
   logic signed [1:0] sgn;
   logic fire;
   logic full;
   logic [CNT_W-1:0] fill_mid;
   logic [PTR_W-1:0] scc_mid;
   logic signed [SUM_W-1:0] ssum_new, tsum_new, sabs, tabs;
   logic [20:0] slim, tlim;
   logic half;

   // Register port writes and reads.
   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[4:2];
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= '0;
         rev_ff <= '0;
         trl_ff <= '0;
         sthr_ff <= '0;
         tthr_ff <= '0;
         wlen_ff <= 6'd32;
      end else if (cfg_wr) begin
         case (reg_idx)
            REG_FWD_LIMIT: fwd_ff <= csr_pwdata[14:0];
            REG_REV_LIMIT: rev_ff <= csr_pwdata[14:0];
            REG_TURN_LIMIT: trl_ff <= csr_pwdata[14:0];
            REG_SPEED_THR: sthr_ff <= csr_pwdata[14:0];
            REG_TURN_THR: tthr_ff <= csr_pwdata[14:0];
            REG_WIN_LEN: wlen_ff <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (reg_idx)
         REG_FWD_LIMIT: csr_prdata = {17'd0, fwd_ff};
         REG_REV_LIMIT: csr_prdata = {17'd0, rev_ff};
         REG_TURN_LIMIT: csr_prdata = {17'd0, trl_ff};
         REG_SPEED_THR: csr_prdata = {17'd0, sthr_ff};
         REG_TURN_THR: csr_prdata = {17'd0, tthr_ff};
         REG_WIN_LEN: csr_prdata = {26'd0, wlen_ff};
         default: csr_prdata = '0;
      endcase
   end

   // Effective window length and pointer wrap.
   assign len = (wlen_ff < 6'd2) ? 6'd2 : ((wlen_ff > 6'(WINDOW_DEPTH)) ?
                6'(WINDOW_DEPTH) : wlen_ff);
   assign wp_eff = ({1'b0, wp_ff} >= len) ? '0 : wp_ff;
   assign nxt_ptr = ({1'b0, wp_eff} + 6'd1 >= len) ? '0 : PTR_W'(wp_eff + 1'b1);
   assign full = fill_ff >= len;

   assign req_ready = (state_ff == ST_IDLE) && (!rv_ff || rsp_ready);
   assign fire = req_valid && req_ready;

   assign lin_abs = lin_ff[15] ? 15'(-lin_ff) : lin_ff[14:0];
   assign trn_abs = trn_ff[15] ? 15'(-trn_ff) : trn_ff[14:0];
   assign sgn = trn_ff[15] ? -2'sd1 : ((trn_ff == 16'sd0) ? 2'sd0 : 2'sd1);

   // Divider requests: speed with the transfer itself, turn rate once speed is done.
   always_comb begin
      dctl = '0;
      dmag = {lin_ff[15] && lin_abs == 15'd0, lin_abs};
      ddiv = lin_ff[15] ? rev_ff : fwd_ff;
      if (state_ff == ST_SPEED && ddone) begin
         dctl.start = 1'b1;
         dctl.negative = trn_ff[15];
         dctl.bypass = trl_ff == 15'd0;
         dmag = {trn_ff[15] && trn_abs == 15'd0, trn_abs};
         ddiv = trl_ff;
      end else if (fire && req_operation == OP_SAMPLE) begin
         dctl.start = 1'b1;
         dctl.negative = req_linear_speed[15];
         dctl.bypass = req_linear_speed[15] ? rev_ff == 15'd0 : fwd_ff == 15'd0;
         dmag = req_linear_speed[15] ? 16'(-req_linear_speed) : req_linear_speed;
         ddiv = req_linear_speed[15] ? rev_ff : fwd_ff;
      end
   end

   vod_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (dctl),
      .magnitude (dmag),
      .divisor   (ddiv),
      .done      (ddone),
      .result    (dres)
   );

   // Window memory: the leaving entry is captured in ST_RD1, and its successor
   // is on the read port during the update step.
   assign ram_ra = (state_ff == ST_RD0) ? wp_eff : nxt_ptr;
   assign ram_we = state_ff == ST_UPD;
   assign ram_wd = '{speed: nspd_ff, turn: ntrn_ff, sign: sgn};

   vod_ram #(.WIDTH(ENTRY_W), .DEPTH(WINDOW_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_eff),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // Window update arithmetic.
   always_comb begin
      ssum_new = ssum_ff;
      tsum_new = tsum_ff;
      scc_mid = scc_ff;
      fill_mid = fill_ff;
      if (full) begin
         ssum_new = ssum_new - SUM_W'(old_ff.speed);
         tsum_new = tsum_new - SUM_W'(old_ff.turn);
         if (old_ff.sign != ram_rd.sign && scc_mid != '0) begin
            scc_mid = scc_mid - 1'b1;
         end
         fill_mid = CNT_W'(len - 6'd1);
      end
      if (fill_mid != '0 && nsign_ff != sgn) begin
         scc_mid = scc_mid + 1'b1;
      end
      ssum_new = ssum_new + SUM_W'(nspd_ff);
      tsum_new = tsum_new + SUM_W'(ntrn_ff);
      fill_mid = fill_mid + 1'b1;
      sabs = ssum_new[SUM_W-1] ? -ssum_new : ssum_new;
      tabs = tsum_new[SUM_W-1] ? -tsum_new : tsum_new;
      slim = 21'(sthr_ff) * 21'(fill_mid);
      tlim = 21'(tthr_ff) * 21'(fill_mid);
      half = 6'(fill_mid) >= {1'b0, len[5:1]};
   end

   // Sequencer and state update.
   assign clear_win = cfg_wr && reg_idx == REG_WIN_LEN;
   always_comb begin
      state_in = state_ff;
      ssum_in = ssum_ff;
      tsum_in = tsum_ff;
      scc_in = scc_ff;
      fill_in = fill_ff;
      wp_in = wp_ff;
      nsign_in = nsign_ff;
      flag_in = flag_ff;
      nspd_in = nspd_ff;
      ntrn_in = ntrn_ff;
      old_in = old_ff;
      rv_in = rv_ff && !rsp_ready;
      ro_in = ro_ff;
      rd_in = rd_ff;
      rc_in = rc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               state_in = (req_operation == OP_CLEAR) ? ST_OUT : ST_SPEED;
               if (req_operation == OP_CLEAR) begin
                  ssum_in = '0;
                  tsum_in = '0;
                  scc_in = '0;
                  fill_in = '0;
                  wp_in = '0;
                  nsign_in = '0;
                  flag_in = 1'b0;
               end
            end
         end
         ST_SPEED: begin
            if (ddone) begin
               nspd_in = (lin_ff == 16'sd0) ? 16'sd0 : dres;
               state_in = ST_TURN;
            end
         end
         ST_TURN: begin
            if (ddone) begin
               ntrn_in = dres;
               state_in = ST_RD0;
            end
         end
         ST_RD0: state_in = ST_RD1;
         ST_RD1: begin
            old_in = ram_rd;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            ssum_in = ssum_new;
            tsum_in = tsum_new;
            scc_in = scc_mid;
            fill_in = fill_mid;
            wp_in = nxt_ptr;
            nsign_in = sgn;
            flag_in = half && (21'(sabs) < slim) && (21'(tabs) < tlim) && (scc_mid > 1);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               ro_in = flag_ff;
               rd_in = 6'(fill_ff) >= {1'b0, len[5:1]};
               rc_in = 6'(fill_ff);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (clear_win) begin
         ssum_in = '0;
         tsum_in = '0;
         scc_in = '0;
         fill_in = '0;
         wp_in = '0;
         nsign_in = '0;
         flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ssum_ff <= '0;
         tsum_ff <= '0;
         scc_ff <= '0;
         fill_ff <= '0;
         wp_ff <= '0;
         nsign_ff <= '0;
         flag_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ssum_ff <= ssum_in;
         tsum_ff <= tsum_in;
         scc_ff <= scc_in;
         fill_ff <= fill_in;
         wp_ff <= wp_in;
         nsign_ff <= nsign_in;
         flag_ff <= flag_in;
         rv_ff <= rv_in;
      end
      if (fire) begin
         lin_ff <= req_linear_speed;
         trn_ff <= req_turn_rate;
      end
      nspd_ff <= nspd_in;
      ntrn_ff <= ntrn_in;
      old_ff <= old_in;
      ro_ff <= ro_in;
      rd_ff <= rd_in;
      rc_ff <= rc_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_oscillating = ro_ff;
   assign rsp_detecting = rd_ff;
   assign rsp_sample_count = rc_ff;

   // The window never holds more samples than its effective length.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      6'(fill_ff) <= len)
      else $error("fill count beyond window length");

   // A raised flag needs more than one sign change.
   a_flag_scc: assert property (@(posedge clock) disable iff (reset)
      flag_ff |-> scc_ff > 1)
      else $error("flag without sign changes");

   // The memory is written only in the update step.
   a_wr_once: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> state_ff == ST_OUT)
      else $error("write outside update");

   // No transfer is taken while an item is in flight.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("accept while busy");

endmodule
